>>> rtl/postfix_expression_evaluator_defines.svh
// Assertion macros for the postfix expression evaluator.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define PEV_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pev assertion failed");
`define PEV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pev assertion failed");
`else
`define PEV_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PEV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/pev_pkg.sv
// Shared constants, types and command/status structs of the postfix evaluator.
package pev_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned MD_CNT_W    = $clog2(DATA_WIDTH + 1);

  typedef logic [DATA_WIDTH-1:0]     data_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [SYM_W-1:0]          sym_t;

  localparam sym_t CH_PLUS  = 8'h2B;
  localparam sym_t CH_MINUS = 8'h2D;
  localparam sym_t CH_STAR  = 8'h2A;
  localparam sym_t CH_SLASH = 8'h2F;
  localparam sym_t CH_0     = 8'h30;
  localparam sym_t CH_9     = 8'h39;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_DIVZ  = 2'd3
  } err_e;

  typedef struct packed {
    logic load;
    logic pop;
    logic cap_r;
    logic cap_l;
    logic md_start;
    logic push;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_op;
    logic is_md;
    logic is_digit;
    logic last;
    logic md_done;
    logic out_busy;
  } sts_t;

endpackage

>>> rtl/pev_md.sv
// Iterative multiply and divide unit, one result bit per cycle.
module pev_md (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        div_i,
  input  pev_pkg::data_t              a_i,
  input  pev_pkg::data_t              b_i,
  output logic                        done_o,
  output logic                        divz_o,
  output pev_pkg::data_t              result_o
);

  localparam int unsigned W = pev_pkg::DATA_WIDTH;

  logic                          run_q;
  logic [pev_pkg::MD_CNT_W-1:0]  cnt_q;
  pev_pkg::data_t                acc_q, x_q, y_q;
  logic                          div_q, neg_q, divz_q;

  logic           na, nb;
  pev_pkg::data_t ma, mb;
  logic [W:0]     rem_sh, diff;

  always_comb begin
    na     = a_i[W-1];
    nb     = b_i[W-1];
    ma     = na ? (pev_pkg::data_t'(0) - a_i) : a_i;
    mb     = nb ? (pev_pkg::data_t'(0) - b_i) : b_i;
    rem_sh = {acc_q, x_q[W-1]};
    diff   = rem_sh - {1'b0, y_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= pev_pkg::MD_CNT_W'(W);
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - pev_pkg::MD_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= div_i;
      acc_q <= '0;
      if (div_i) begin
        x_q    <= ma;
        y_q    <= mb;
        neg_q  <= na ^ nb;
        divz_q <= (mb == '0);
      end else begin
        x_q    <= a_i;
        y_q    <= b_i;
        neg_q  <= 1'b0;
        divz_q <= 1'b0;
      end
    end else if (run_q && (cnt_q != '0)) begin
      if (div_q) begin
        if (!diff[W]) begin
          acc_q <= diff[W-1:0];
          x_q   <= {x_q[W-2:0], 1'b1};
        end else begin
          acc_q <= rem_sh[W-1:0];
          x_q   <= {x_q[W-2:0], 1'b0};
        end
      end else begin
        if (y_q[0]) begin
          acc_q <= acc_q + x_q;
        end
        x_q <= {x_q[W-2:0], 1'b0};
        y_q <= {1'b0, y_q[W-1:1]};
      end
    end
  end

  always_comb begin
    done_o = run_q && (cnt_q == '0);
    divz_o = done_o && div_q && divz_q;
    if (!div_q) begin
      result_o = acc_q;
    end else if (divz_q) begin
      result_o = '0;
    end else if (neg_q) begin
      result_o = pev_pkg::data_t'(0) - x_q;
    end else begin
      result_o = x_q;
    end
  end

endmodule

>>> rtl/pev_dp.sv
// Datapath: stack memory, operand registers, add/sub, mul/div unit, error flag, result register.
module pev_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pev_pkg::sym_t         symbol_i,
  input  logic                  last_i,
  input  pev_pkg::cmd_t         cmd_i,
  output pev_pkg::sts_t         sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output pev_pkg::value_t       value_o,
  output logic [1:0]            status_o
);

  pev_pkg::data_t              mem [pev_pkg::STACK_DEPTH];

  pev_pkg::sym_t               sym_q;
  logic                        last_q;
  logic [pev_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  pev_pkg::err_e               err_q, err_d;
  pev_pkg::data_t              rdata_q, right_q, left_q;
  logic                        empty_q;
  pev_pkg::value_t             out_value_q;
  pev_pkg::err_e               out_status_q;
  logic                        out_valid_q, out_valid_d;

  logic                        is_add, is_sub, is_mul, is_div, is_digit, full;
  logic [pev_pkg::CNT_W-1:0]   cnt_dec;
  logic [pev_pkg::IDX_W-1:0]   rd_idx, wr_idx;
  pev_pkg::data_t              opnd, push_val, md_res;
  logic                        md_done, md_divz;

  pev_md u_md (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.md_start),
    .div_i    (is_div),
    .a_i      (left_q),
    .b_i      (right_q),
    .done_o   (md_done),
    .divz_o   (md_divz),
    .result_o (md_res)
  );

  always_comb begin
    is_add   = (sym_q == pev_pkg::CH_PLUS);
    is_sub   = (sym_q == pev_pkg::CH_MINUS);
    is_mul   = (sym_q == pev_pkg::CH_STAR);
    is_div   = (sym_q == pev_pkg::CH_SLASH);
    is_digit = (sym_q >= pev_pkg::CH_0) && (sym_q <= pev_pkg::CH_9);
    full     = (cnt_q == pev_pkg::CNT_W'(pev_pkg::STACK_DEPTH));
    cnt_dec  = cnt_q - pev_pkg::CNT_W'(1);
    rd_idx   = cnt_dec[pev_pkg::IDX_W-1:0];
    wr_idx   = cnt_q[pev_pkg::IDX_W-1:0];
    opnd     = empty_q ? '0 : rdata_q;

    priority if (is_digit) begin
      push_val = pev_pkg::data_t'(4'(sym_q - pev_pkg::CH_0));
    end else if (is_add) begin
      push_val = left_q + right_q;
    end else if (is_sub) begin
      push_val = left_q - right_q;
    end else begin
      push_val = md_res;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    err_d = err_q;
    if (cmd_i.pop) begin
      if (cnt_q == '0) begin
        if (err_d == pev_pkg::ERR_NONE) err_d = pev_pkg::ERR_UNDER;
      end else begin
        cnt_d = cnt_dec;
      end
    end
    if (md_divz) begin
      if (err_d == pev_pkg::ERR_NONE) err_d = pev_pkg::ERR_DIVZ;
    end
    if (cmd_i.push) begin
      if (full) begin
        if (err_d == pev_pkg::ERR_NONE) err_d = pev_pkg::ERR_OVER;
      end else begin
        cnt_d = cnt_q + pev_pkg::CNT_W'(1);
      end
    end
    if (cmd_i.emit) begin
      cnt_d = '0;
      err_d = pev_pkg::ERR_NONE;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      err_q       <= pev_pkg::ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !full) begin
      mem[wr_idx] <= push_val;
    end
    rdata_q <= mem[rd_idx];
    empty_q <= (cnt_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sym_q  <= symbol_i;
      last_q <= last_i;
    end
    if (cmd_i.cap_r) right_q <= opnd;
    if (cmd_i.cap_l) left_q  <= opnd;
    if (cmd_i.emit) begin
      out_value_q  <= pev_pkg::value_t'($signed(opnd));
      out_status_q <= err_q;
    end
  end

  always_comb begin
    sts_o.is_op    = is_add || is_sub || is_mul || is_div;
    sts_o.is_md    = is_mul || is_div;
    sts_o.is_digit = is_digit;
    sts_o.last     = last_q;
    sts_o.md_done  = md_done;
    sts_o.out_busy = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign status_o    = 2'(out_status_q);

endmodule

>>> rtl/pev_ctrl.sv
// Controller state machine sequencing decode, pops, arithmetic, push and result.
module pev_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pev_pkg::sts_t sts_i,
  output pev_pkg::cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_DECODE  = 10'b00_0000_0010,
    S_POP_R   = 10'b00_0000_0100,
    S_POP_L   = 10'b00_0000_1000,
    S_CAP_L   = 10'b00_0001_0000,
    S_EXEC    = 10'b00_0010_0000,
    S_MD_WAIT = 10'b00_0100_0000,
    S_PUSH    = 10'b00_1000_0000,
    S_RD_TOP  = 10'b01_0000_0000,
    S_EMIT    = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts_i.is_op) begin
          state_d = S_POP_R;
        end else if (sts_i.is_digit) begin
          state_d = S_PUSH;
        end else if (sts_i.last) begin
          state_d = S_RD_TOP;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_POP_R: begin
        cmd_o.pop = 1'b1;
        state_d   = S_POP_L;
      end
      S_POP_L: begin
        cmd_o.pop   = 1'b1;
        cmd_o.cap_r = 1'b1;
        state_d     = S_CAP_L;
      end
      S_CAP_L: begin
        cmd_o.cap_l = 1'b1;
        state_d     = sts_i.is_md ? S_EXEC : S_PUSH;
      end
      S_EXEC: begin
        cmd_o.md_start = 1'b1;
        state_d        = S_MD_WAIT;
      end
      S_MD_WAIT: begin
        if (sts_i.md_done) state_d = S_PUSH;
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = sts_i.last ? S_RD_TOP : S_IDLE;
      end
      S_RD_TOP: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/postfix_expression_evaluator.sv
// Top level of the postfix expression evaluator: controller, datapath, assertions.
// One word at a time: ignored character IDLE, DECODE; digit adds PUSH; + or - POP_R, POP_L,
// CAP_L, PUSH; * or / adds EXEC, MD_WAIT, where the shift-add / restoring unit retires one bit
// per cycle. A word with last set adds RD_TOP, EMIT; the result word is registered and the next
// word is accepted while it waits; stalls only if a second result meets a full slot.
// Reset clears the state machine, stack count and error flag; stack memory is not cleared.
`include "postfix_expression_evaluator_defines.svh"

module postfix_expression_evaluator (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            symbol_i,
  input  logic                  last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [31:0]    value_o,
  output logic [1:0]            status_o
);

  pev_pkg::cmd_t cmd;
  pev_pkg::sts_t sts;

  pev_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pev_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .symbol_i    (symbol_i),
    .last_i      (last_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .value_o     (value_o),
    .status_o    (status_o)
  );

  `PEV_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `PEV_ASSERT_SAME(a_emit_free, clk_i, rst_ni, cmd.emit, !(out_valid_o && !out_ready_i))
  `PEV_ASSERT_SAME(a_out_from_emit, clk_i, rst_ni, $rose(out_valid_o), $past(cmd.emit))

endmodule

>>> tb/postfix_expression_evaluator_test.sv
// Self-checking testbench for the postfix evaluator: random RPN words against a stack predictor.
module postfix_expression_evaluator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned DRAIN_WAIT  = 60;
  localparam int unsigned TAIL_WORDS  = 150;
  localparam int unsigned WORD_TARGET = 2000;
  localparam int unsigned DRAIN_EVERY = 700;
  localparam int unsigned HOLD_AFTER  = 60;

  typedef struct {
    pev_pkg::sym_t code;
    logic          fin;
    bit            drain;
  } word_t;

  typedef struct {
    pev_pkg::value_t value;
    pev_pkg::err_e   status;
  } outcome_t;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            sym_valid = 1'b0;
  logic            sym_last  = 1'b0;
  logic            res_ready = 1'b0;
  pev_pkg::sym_t   sym_code  = '0;
  logic            in_ready;
  logic            out_valid;
  pev_pkg::value_t value;
  logic [1:0]      status;

  word_t    pend_q[$];
  outcome_t outcome_q[$];

  pev_pkg::data_t stack_mem [pev_pkg::STACK_DEPTH];
  int unsigned    stack_fill = 0;
  pev_pkg::err_e  sticky_err = pev_pkg::ERR_NONE;

  int unsigned counted_words = 0;
  int unsigned words_sent    = 0;
  int unsigned results_due   = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned status_hits [4] = '{0, 0, 0, 0};
  int unsigned send_gap      = 0;
  int unsigned hold_left     = 0;
  int unsigned stall_cycles  = 0;
  bit          drain_next    = 1'b0;
  bit          quiet_tail    = 1'b0;
  bit          send_bursty   = 1'b1;
  bit          recv_bursty   = 1'b1;
  bit          long_hold_done = 1'b0;

  postfix_expression_evaluator u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (sym_valid),
    .in_ready_o  (in_ready),
    .symbol_i    (sym_code),
    .last_i      (sym_last),
    .out_valid_o (out_valid),
    .out_ready_i (res_ready),
    .value_o     (value),
    .status_o    (status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit is_operator(pev_pkg::sym_t c);
    return c == pev_pkg::CH_PLUS || c == pev_pkg::CH_MINUS ||
           c == pev_pkg::CH_STAR || c == pev_pkg::CH_SLASH;
  endfunction

  function automatic bit is_digit(pev_pkg::sym_t c);
    return c >= pev_pkg::CH_0 && c <= pev_pkg::CH_9;
  endfunction

  function automatic void note_fault(pev_pkg::err_e code);
    if (sticky_err == pev_pkg::ERR_NONE) sticky_err = code;
  endfunction

  function automatic void push_operand(pev_pkg::data_t v);
    if (stack_fill >= pev_pkg::STACK_DEPTH) begin
      note_fault(pev_pkg::ERR_OVER);
    end else begin
      stack_mem[stack_fill] = v;
      stack_fill++;
    end
  endfunction

  function automatic pev_pkg::data_t pop_operand();
    if (stack_fill == 0) begin
      note_fault(pev_pkg::ERR_UNDER);
      return '0;
    end
    stack_fill--;
    return stack_mem[stack_fill];
  endfunction

  // truncate toward zero on magnitudes; most negative over -1 wraps back to itself
  function automatic pev_pkg::data_t signed_quotient(pev_pkg::data_t num, pev_pkg::data_t den);
    pev_pkg::data_t num_mag;
    pev_pkg::data_t den_mag;
    pev_pkg::data_t quo;
    num_mag = num[pev_pkg::DATA_WIDTH-1] ? -num : num;
    den_mag = den[pev_pkg::DATA_WIDTH-1] ? -den : den;
    if (den_mag == '0) begin
      note_fault(pev_pkg::ERR_DIVZ);
      return '0;
    end
    quo = num_mag / den_mag;
    return (num[pev_pkg::DATA_WIDTH-1] != den[pev_pkg::DATA_WIDTH-1]) ? -quo : quo;
  endfunction

  task automatic evaluate_word(pev_pkg::sym_t code, logic fin);
    pev_pkg::data_t rhs;
    pev_pkg::data_t lhs;
    pev_pkg::data_t res;
    outcome_t       due;
    if (is_operator(code)) begin
      rhs = pop_operand();
      lhs = pop_operand();
      unique case (code)
        pev_pkg::CH_PLUS:  res = lhs + rhs;
        pev_pkg::CH_MINUS: res = lhs - rhs;
        pev_pkg::CH_STAR:  res = lhs * rhs;
        default:           res = signed_quotient(lhs, rhs);
      endcase
      push_operand(res);
    end else if (is_digit(code)) begin
      push_operand(pev_pkg::data_t'(code - pev_pkg::CH_0));
    end
    if (fin) begin
      due.value  = (stack_fill > 0) ?
                   pev_pkg::value_t'($signed(stack_mem[stack_fill-1])) : '0;
      due.status = sticky_err;
      outcome_q.push_back(due);
      status_hits[int'(sticky_err)]++;
      results_due++;
      stack_fill = 0;
      sticky_err = pev_pkg::ERR_NONE;
    end
  endtask

  function automatic pev_pkg::sym_t digit_sym(int unsigned d);
    return pev_pkg::sym_t'(pev_pkg::CH_0 + d);
  endfunction

  function automatic pev_pkg::sym_t any_operator();
    unique case ($urandom_range(0, 3))
      0:       return pev_pkg::CH_PLUS;
      1:       return pev_pkg::CH_MINUS;
      2:       return pev_pkg::CH_STAR;
      default: return pev_pkg::CH_SLASH;
    endcase
  endfunction

  function automatic pev_pkg::sym_t ignored_sym();
    pev_pkg::sym_t c;
    do c = pev_pkg::sym_t'($urandom_range(0, 255));
    while (is_operator(c) || is_digit(c));
    return c;
  endfunction

  task automatic add_word(pev_pkg::sym_t c, logic fin);
    word_t w;
    w.code  = c;
    w.fin   = fin;
    w.drain = drain_next;
    drain_next = 1'b0;
    pend_q.push_back(w);
    if (is_operator(c) || is_digit(c)) counted_words++;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_word(pev_pkg::sym_t'(s[i]), i == s.len() - 1);
  endtask

  task automatic gen_formed();
    int unsigned operands;
    int unsigned depth;
    bit          tail_ignored;
    operands     = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
    depth        = 0;
    tail_ignored = ($urandom_range(0, 9) == 0);
    while (operands != 0 || depth > 1) begin
      if ($urandom_range(0, 9) == 0) add_word(ignored_sym(), 1'b0);
      if (operands != 0 && (depth < 2 || $urandom_range(0, 1) == 0)) begin
        operands--;
        depth++;
        add_word(digit_sym($urandom_range(0, 9)), !tail_ignored && operands == 0 && depth == 1);
      end else begin
        depth--;
        add_word(any_operator(), !tail_ignored && operands == 0 && depth == 1);
      end
    end
    if (tail_ignored) add_word(ignored_sym(), 1'b1);
  endtask

  task automatic gen_broken();
    int unsigned len;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      add_word($urandom_range(0, 1) ? any_operator() : digit_sym($urandom_range(0, 9)),
               i == len - 1);
    end
  endtask

  task automatic gen_noise();
    int unsigned len;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      add_word(pev_pkg::sym_t'($urandom_range(0, 255)),
               i == len - 1 || $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic gen_deep_mul();
    int unsigned steps;
    steps = $urandom_range(10, 14);
    add_word(digit_sym($urandom_range(5, 9)), 1'b0);
    for (int i = 0; i < steps; i++) begin
      add_word(digit_sym($urandom_range(2, 9)), 1'b0);
      add_word(($urandom_range(0, 4) != 0) ? pev_pkg::CH_STAR : any_operator(),
               i == steps - 1);
    end
  endtask

  task automatic gen_overflow();
    int unsigned len;
    len = $urandom_range(17, 20);
    for (int i = 0; i < len; i++) add_word(digit_sym($urandom_range(0, 9)), i == len - 1);
  endtask

  // build 8^10 * 2, which wraps to the most negative value, then apply -1
  task automatic gen_most_negative();
    if ($urandom_range(0, 1)) add_text("88888888882**********01-/");
    else add_text("88888888882**********01-*");
  endtask

  initial begin
    int unsigned pick;
    int unsigned next_drain;
    add_text("01234567890123456");
    add_text("90/");
    add_text("-");
    add_text("98+7*");
    add_word(8'hFF, 1'b1);
    next_drain = DRAIN_EVERY;
    while (counted_words < WORD_TARGET) begin
      if (counted_words >= next_drain) begin
        drain_next = 1'b1;
        next_drain += DRAIN_EVERY;
      end
      pick = $urandom_range(0, 99);
      if (pick < 68) gen_formed();
      else if (pick < 78) gen_broken();
      else if (pick < 86) gen_noise();
      else if (pick < 93) gen_deep_mul();
      else if (pick < 97) gen_overflow();
      else gen_most_negative();
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (pend_q.size() != 0 || sym_valid || outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d words sent, %0d expressions checked (%0d clean, %0d underflow,",
             words_sent, results_seen, status_hits[0], status_hits[1]);
    $display("%0d overflow, %0d divide by zero), %0d mismatches, %0d results outstanding",
             status_hits[2], status_hits[3], mismatches, outcome_q.size());
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("postfix_expression_evaluator verification clean");
    end else begin
      $display("postfix_expression_evaluator verification failed");
    end
    $finish;
  end

  always @(posedge clk or negedge rst_n) begin
    word_t nxt;
    if (!rst_n) begin
      sym_valid  <= 1'b0;
      sym_code   <= '0;
      sym_last   <= 1'b0;
      quiet_tail <= 1'b0;
    end else begin
      if (sym_valid && in_ready) begin
        evaluate_word(sym_code, sym_last);
        words_sent++;
      end
      quiet_tail <= (pend_q.size() < TAIL_WORDS);
      if ($urandom_range(0, 49) == 0) send_bursty = !send_bursty;
      if (!sym_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          sym_valid <= 1'b0;
        end else if (pend_q.size() == 0 || (pend_q[0].drain && results_seen != results_due)) begin
          sym_valid <= 1'b0;
        end else if (send_bursty && !quiet_tail && $urandom_range(0, 3) == 0) begin
          send_gap = $urandom_range(0, 2);
          sym_valid <= 1'b0;
        end else begin
          nxt = pend_q.pop_front();
          sym_code  <= nxt.code;
          sym_last  <= nxt.fin;
          sym_valid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    outcome_t want;
    if (!rst_n) begin
      res_ready    <= 1'b0;
      results_seen <= 0;
    end else begin
      if (out_valid && res_ready) begin
        results_seen <= results_seen + 1;
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result word: value %0d status %0d", value, status);
          end
        end else begin
          want = outcome_q.pop_front();
          if (value !== want.value || status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d: value %0d status %0d, expected value %0d status %0d",
                       results_seen, value, status, want.value, want.status);
            end
          end
        end
      end
      if ($urandom_range(0, 49) == 0) recv_bursty = !recv_bursty;
      if (hold_left != 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        res_ready <= 1'b0;
      end else if (recv_bursty && !quiet_tail && $urandom_range(0, 3) == 0) begin
        hold_left = $urandom_range(0, 2);
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (sym_valid && in_ready) || (out_valid && res_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= IDLE_LIMIT) begin
      $display("no word moved for %0d cycles", IDLE_LIMIT);
      $display("postfix_expression_evaluator verification failed");
      $finish;
    end
  end

endmodule
